// ===== sv/assert_macros.svh =====
// assertion helpers included by the sample unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition a implies condition b in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");

// condition a is followed by condition b a fixed number of cycles later
`define ASSERT_DELAY(label, clk, rst, a, n, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (b)) \
      else $error("delayed check failed");

`endif

// ===== sv/dmws_pkg.sv =====
package dmws_pkg;

   localparam int COS_BITS_DEFAULT = 16;
   localparam int ATAN_COUNT = 24;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [47:0] ROT_RATE = 48'd214088364978877;
   localparam logic [47:0] ORB_RATE = 48'd586125951319;
   localparam logic [28:0] KORB = 29'd523251888;
   localparam logic [14:0] KROT = 15'd22284;

   localparam logic [31:0] ATAN_TABLE [ATAN_COUNT] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
      32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
      32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304,
      32'd652, 32'd326, 32'd163, 32'd81
   };

   // arctangent of 2^-i in q0.32 cycles, zero extended
   function automatic logic signed [33:0] atan_cycles(input logic [4:0] idx);
      return signed'({2'b00, ATAN_TABLE[idx]});
   endfunction

endpackage

// ===== sv/dmws_cordic.sv =====
module dmws_cordic #(
   parameter int COS_BITS = dmws_pkg::COS_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [31:0]                in_angle,
   output logic                       out_valid,
   output logic signed [COS_BITS+1:0] out_cos
);

   localparam logic signed [33:0] ONE = signed'(34'(1) << COS_BITS);
   localparam logic signed [33:0] RND = signed'(34'(1) << (29 - COS_BITS));

   logic                val_ff  [COS_BITS+1];
   logic                flip_ff [COS_BITS+1];
   logic signed [33:0]  x_ff    [COS_BITS+1];
   logic signed [33:0]  y_ff    [COS_BITS+1];
   logic signed [33:0]  z_ff    [COS_BITS+1];
   logic signed [33:0]  x_in    [COS_BITS];
   logic signed [33:0]  y_in    [COS_BITS];
   logic signed [33:0]  z_in    [COS_BITS];

   logic                    flip_in;
   logic [31:0]             angle_in;
   logic signed [33:0]      round_in;
   logic signed [33:0]      clamp_in;
   logic signed [COS_BITS+1:0] cos_in;
   logic                    out_valid_ff;
   logic signed [COS_BITS+1:0] out_cos_ff;

   // fold the angle into the right half plane
   always_comb begin
      flip_in  = in_angle[31] ^ in_angle[30];
      angle_in = {in_angle[31] ^ flip_in, in_angle[30:0]};
   end

   always_comb begin
      for (int i = 0; i < COS_BITS; i++) begin
         if (!z_ff[i][33]) begin
            x_in[i] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i] = z_ff[i] - dmws_pkg::atan_cycles(5'(i));
         end else begin
            x_in[i] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i] = z_ff[i] + dmws_pkg::atan_cycles(5'(i));
         end
      end
   end

   always_comb begin
      round_in = (x_ff[COS_BITS] + RND) >>> (30 - COS_BITS);
      if (round_in > ONE) begin
         clamp_in = ONE;
      end else if (round_in < -ONE) begin
         clamp_in = -ONE;
      end else begin
         clamp_in = round_in;
      end
      cos_in = flip_ff[COS_BITS] ? -clamp_in[COS_BITS+1:0] : clamp_in[COS_BITS+1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= COS_BITS; i++) begin
            val_ff[i] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         val_ff[0] <= in_valid;
         for (int i = 0; i < COS_BITS; i++) begin
            val_ff[i+1] <= val_ff[i];
         end
         out_valid_ff <= val_ff[COS_BITS];
      end
   end

   always_ff @(posedge clock) begin
      flip_ff[0] <= flip_in;
      x_ff[0]    <= dmws_pkg::CORDIC_GAIN;
      y_ff[0]    <= '0;
      z_ff[0]    <= 34'(signed'(angle_in));
      for (int i = 0; i < COS_BITS; i++) begin
         flip_ff[i+1] <= flip_ff[i];
         x_ff[i+1]    <= x_in[i];
         y_ff[i+1]    <= y_in[i];
         z_ff[i+1]    <= z_in[i];
      end
      out_cos_ff <= cos_in;
   end

   assign out_valid = out_valid_ff;
   assign out_cos   = out_cos_ff;

endmodule

// ===== sv/doppler_modulated_wave_sample_unit.sv =====
// channel  | ports                          | direction
// request  | start, busy, req_freq_hz/time  | in
// response | rsp_valid, rsp_wave_value      | out
//
// one word accepted every cycle; busy stays low
// start travels to the rsp_valid strobe through the pipeline,
// which passes two cordic chains in series of COS_BITS+2 stages each
// synchronous reset clears the valid bits of every stage
// results cannot be held off, so the pipeline never stalls
`include "assert_macros.svh"

module doppler_modulated_wave_sample_unit #(
   parameter int COS_BITS = dmws_pkg::COS_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_freq_hz,
   input  logic [47:0] req_time_s,
   output logic        rsp_valid,
   output logic [16:0] rsp_wave_value
);

   localparam int LC      = COS_BITS + 2;
   localparam int LATENCY = 2 * COS_BITS + 11;
   localparam int SH_DN   = (COS_BITS > 15) ? COS_BITS - 15 : 0;
   localparam int SH_UP   = (COS_BITS < 15) ? 15 - COS_BITS : 0;
   localparam int RND_SH  = (COS_BITS > 15) ? COS_BITS - 16 : 0;
   localparam logic [31:0] FULL = 32'd65536;

   // stage 1: input register
   logic        v1_ff;
   logic [31:0] fr1_ff;
   logic [47:0] t1_ff;

   // stage 2: partial products
   logic        v2_ff;
   logic [47:0] rot_p_ff [4];
   logic [47:0] orb_p_ff [4];
   logic [63:0] pa_ff;
   logic [15:0] pb_ff;
   logic [60:0] frk_orb2_ff;
   logic [46:0] frk_rot2_ff;

   // stage 3: angles and raw phase
   logic        v3_ff;
   logic [31:0] ang_rot_ff;
   logic [31:0] ang_orb_ff;
   logic [31:0] phase3_ff;
   logic [60:0] frk_orb3_ff;
   logic [46:0] frk_rot3_ff;
   logic [95:0] rot_sum_in;
   logic [95:0] orb_sum_in;
   logic [39:0] phase_sum_in;

   // side data delayed alongside the cordic
   logic [60:0] orb_dl_ff   [LC];
   logic [46:0] rot_dl_ff   [LC];
   logic [31:0] phase_dl_ff [LC];

   logic                       orb_valid;
   logic                       rot_valid;
   logic signed [COS_BITS+1:0] orb_cos;
   logic signed [COS_BITS+1:0] rot_cos;

   // d1: doppler products
   logic                       d1_valid_ff;
   logic [63:0]                orb_lo_ff;
   logic [31:0]                orb_hi_ff;
   logic [63:0]                rot_lo_ff;
   logic [31:0]                rot_hi_ff;
   logic [31:0]                phase_d1_ff;
   logic [COS_BITS+1:0]        orb_m_in;
   logic [COS_BITS+1:0]        rot_m_in;
   logic [63:0]                orb_hi_in;
   logic [63:0]                rot_hi_in;

   // d2: doppler terms
   logic        d2_valid_ff;
   logic [31:0] orb_term_ff;
   logic [31:0] rot_term_ff;
   logic [31:0] phase_d2_ff;
   logic [63:0] orb_full_in;
   logic [63:0] rot_full_in;

   // d3: corrected phase
   logic        d3_valid_ff;
   logic [31:0] phase_d3_ff;

   logic                       wave_valid;
   logic signed [COS_BITS+1:0] wave_cos;
   logic [COS_BITS+2:0]        lift_in;
   logic [31:0]                scaled_in;
   logic [16:0]                wave_in;
   logic                       rsp_valid_ff;
   logic [16:0]                rsp_wave_value_ff;

   assign busy = 1'b0;

   always_comb begin
      rot_sum_in = 96'(rot_p_ff[0]) + (96'(rot_p_ff[1]) << 24) + (96'(rot_p_ff[2]) << 24)
                   + (96'(rot_p_ff[3]) << 48);
      orb_sum_in = 96'(orb_p_ff[0]) + (96'(orb_p_ff[1]) << 24) + (96'(orb_p_ff[2]) << 24)
                   + (96'(orb_p_ff[3]) << 48);
      phase_sum_in = pa_ff[39:0] + {pb_ff[7:0], 32'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      fr1_ff <= req_freq_hz;
      t1_ff  <= req_time_s;

      rot_p_ff[0] <= t1_ff[23:0] * dmws_pkg::ROT_RATE[23:0];
      rot_p_ff[1] <= t1_ff[23:0] * dmws_pkg::ROT_RATE[47:24];
      rot_p_ff[2] <= t1_ff[47:24] * dmws_pkg::ROT_RATE[23:0];
      rot_p_ff[3] <= t1_ff[47:24] * dmws_pkg::ROT_RATE[47:24];
      orb_p_ff[0] <= t1_ff[23:0] * dmws_pkg::ORB_RATE[23:0];
      orb_p_ff[1] <= t1_ff[23:0] * dmws_pkg::ORB_RATE[47:24];
      orb_p_ff[2] <= t1_ff[47:24] * dmws_pkg::ORB_RATE[23:0];
      orb_p_ff[3] <= t1_ff[47:24] * dmws_pkg::ORB_RATE[47:24];
      pa_ff       <= 64'(fr1_ff) * 64'(t1_ff[31:0]);
      pb_ff       <= fr1_ff[7:0] * t1_ff[39:32];
      frk_orb2_ff <= 61'(fr1_ff) * 61'(dmws_pkg::KORB);
      frk_rot2_ff <= 47'(fr1_ff) * 47'(dmws_pkg::KROT);

      ang_rot_ff  <= rot_sum_in[83:52];
      ang_orb_ff  <= orb_sum_in[83:52];
      phase3_ff   <= phase_sum_in[39:8];
      frk_orb3_ff <= frk_orb2_ff;
      frk_rot3_ff <= frk_rot2_ff;

      orb_dl_ff[0]   <= frk_orb3_ff;
      rot_dl_ff[0]   <= frk_rot3_ff;
      phase_dl_ff[0] <= phase3_ff;
      for (int i = 1; i < LC; i++) begin
         orb_dl_ff[i]   <= orb_dl_ff[i-1];
         rot_dl_ff[i]   <= rot_dl_ff[i-1];
         phase_dl_ff[i] <= phase_dl_ff[i-1];
      end
   end

   dmws_cordic #(.COS_BITS(COS_BITS)) u_cos_orb (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_angle  (ang_orb_ff),
      .out_valid (orb_valid),
      .out_cos   (orb_cos)
   );

   dmws_cordic #(.COS_BITS(COS_BITS)) u_cos_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_angle  (ang_rot_ff),
      .out_valid (rot_valid),
      .out_cos   (rot_cos)
   );

   // one minus cosine, never negative
   always_comb begin
      orb_m_in  = (COS_BITS+2)'((1 << COS_BITS)) - unsigned'(orb_cos);
      rot_m_in  = (COS_BITS+2)'((1 << COS_BITS)) - unsigned'(rot_cos);
      orb_hi_in = 64'(orb_dl_ff[LC-1][60:32]) * 64'(orb_m_in);
      rot_hi_in = 64'(rot_dl_ff[LC-1][46:32]) * 64'(rot_m_in);
      orb_full_in = orb_lo_ff + {orb_hi_ff, 32'd0};
      rot_full_in = rot_lo_ff + {rot_hi_ff, 32'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff  <= 1'b0;
         d2_valid_ff  <= 1'b0;
         d3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         d1_valid_ff  <= orb_valid;
         d2_valid_ff  <= d1_valid_ff;
         d3_valid_ff  <= d2_valid_ff;
         rsp_valid_ff <= wave_valid;
      end
   end

   always_ff @(posedge clock) begin
      orb_lo_ff   <= 64'(orb_dl_ff[LC-1][31:0]) * 64'(orb_m_in);
      orb_hi_ff   <= orb_hi_in[31:0];
      rot_lo_ff   <= 64'(rot_dl_ff[LC-1][31:0]) * 64'(rot_m_in);
      rot_hi_ff   <= rot_hi_in[31:0];
      phase_d1_ff <= phase_dl_ff[LC-1];

      orb_term_ff <= orb_full_in[8+COS_BITS +: 32];
      rot_term_ff <= rot_full_in[8+COS_BITS +: 32];
      phase_d2_ff <= phase_d1_ff;

      phase_d3_ff <= phase_d2_ff - orb_term_ff - rot_term_ff;

      rsp_wave_value_ff <= wave_in;
   end

   dmws_cordic #(.COS_BITS(COS_BITS)) u_cos_wave (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d3_valid_ff),
      .in_angle  (phase_d3_ff),
      .out_valid (wave_valid),
      .out_cos   (wave_cos)
   );

   // lift to 0..2 and rescale to 15 fraction bits
   always_comb begin
      lift_in = (COS_BITS+3)'(signed'(wave_cos)) + (COS_BITS+3)'((1 << COS_BITS));
      if (COS_BITS > 15) begin
         scaled_in = (32'(lift_in[COS_BITS+1:0]) + (32'd1 << RND_SH)) >> SH_DN;
      end else begin
         scaled_in = 32'(lift_in[COS_BITS+1:0]) << SH_UP;
      end
      if (scaled_in > FULL) begin
         wave_in = FULL[16:0];
      end else begin
         wave_in = scaled_in[16:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_wave_value = rsp_wave_value_ff;

   `ASSERT_IMPLIES(a_cordic_lockstep, clock, reset, 1'b1, orb_valid == rot_valid)
   `ASSERT_IMPLIES(a_wave_range, clock, reset, rsp_valid, rsp_wave_value <= 17'd65536)
   `ASSERT_DELAY(a_latency, clock, reset, start && !busy, LATENCY, rsp_valid)

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

   localparam int CB = dmws_pkg::COS_BITS_DEFAULT;
   localparam int LATENCY = 2 * CB + 11;
   localparam int RANDOM_WORDS = 750;
   localparam longint NO_GLANCE = -1;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_freq_hz;
   logic [47:0] req_time_s;
   logic        rsp_valid;
   logic [16:0] rsp_wave_value;

   logic [16:0] wave_due[$];
   int          mismatches;
   int          words_sent;
   int          words_checked;

   typedef struct {
      logic [31:0] freq;
      logic [47:0] tsec;
      longint      wave;   // typed-in value, or NO_GLANCE for the predictor
   } stim_row_type;

   stim_row_type directed[] = '{
      '{32'd0, 48'd0, 65536},
      '{32'd0, 48'hFFFF_FFFF_FFFF, 65536},
      '{32'd0, 48'h0000_1234_5678, 65536},
      '{32'hFFFF_FFFF, 48'd0, NO_GLANCE},
      '{32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, NO_GLANCE},
      '{32'd1, 48'd1, NO_GLANCE},
      '{32'h0010_0000, 48'h0000_0010_0000, NO_GLANCE},
      '{32'h0010_0000, 48'h0000_0008_0000, NO_GLANCE},
      '{32'h0010_0000, 48'h0000_0004_0000, NO_GLANCE},
      '{32'h0010_0000, 48'h0000_000C_0000, NO_GLANCE},
      '{32'h8000_0000, 48'h8000_0000_0000, NO_GLANCE},
      '{32'h5555_5555, 48'hAAAA_AAAA_AAAA, NO_GLANCE},
      '{32'hAAAA_AAAA, 48'h5555_5555_5555, NO_GLANCE},
      '{32'h0640_0000, 48'h0001_5180_0000, NO_GLANCE},
      '{32'h0000_0001, 48'hFFFF_FFFF_FFFF, NO_GLANCE},
      '{32'hFFFF_FFFF, 48'd1, NO_GLANCE},
      '{32'h0003_2000, 48'h1E13_3800_0000, NO_GLANCE}
   };

   doppler_modulated_wave_sample_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_freq_hz    (req_freq_hz),
      .req_time_s     (req_time_s),
      .rsp_valid      (rsp_valid),
      .rsp_wave_value (rsp_wave_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // bits 52..83 of the product of time and a rate in q0.64 cycles per second
   function automatic logic [31:0] turn_angle(input logic [47:0] tsec, input logic [47:0] rate);
      logic [95:0] prod;
      prod = {48'b0, tsec} * {48'b0, rate};
      return prod[83:52];
   endfunction

   function automatic longint cordic_cos(input logic [31:0] ang);
      logic [31:0] u;
      logic        flip;
      longint      x, y, z, xs, ys, c, one;
      u = ang;
      flip = ((u + 32'h4000_0000) & 32'h8000_0000) != 0;
      if (flip) u = u + 32'h8000_0000;
      x = longint'(dmws_pkg::CORDIC_GAIN);
      y = 0;
      z = longint'($signed(u));
      for (int i = 0; i < CB && i < dmws_pkg::ATAN_COUNT; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - longint'(dmws_pkg::ATAN_TABLE[i]);
         end else begin
            x = x + ys; y = y - xs; z = z + longint'(dmws_pkg::ATAN_TABLE[i]);
         end
      end
      c = (x + (longint'(1) << (29 - CB))) >>> (30 - CB);
      one = longint'(1) << CB;
      if (c > one) c = one;
      if (c < -one) c = -one;
      return flip ? -c : c;
   endfunction

   // phase lag of fr * k * (1 - cos), q0.32 cycles
   function automatic logic [31:0] doppler_lag(input logic [31:0] freq, input logic [63:0] k,
                                               input longint c);
      logic [63:0] m, p;
      m = 64'((longint'(1) << CB) - c);
      p = {32'b0, freq} * k * m;
      return 32'(p >> (8 + CB));
   endfunction

   function automatic logic [16:0] doppler_wave(input logic [31:0] freq, input logic [47:0] tsec);
      logic [79:0] ft;
      logic [31:0] phase;
      longint      v;
      ft = {48'b0, freq} * {32'b0, tsec};
      phase = ft[39:8];
      phase = phase - doppler_lag(freq, 64'(dmws_pkg::KORB),
                                  cordic_cos(turn_angle(tsec, dmws_pkg::ORB_RATE)));
      phase = phase - doppler_lag(freq, 64'(dmws_pkg::KROT),
                                  cordic_cos(turn_angle(tsec, dmws_pkg::ROT_RATE)));
      v = cordic_cos(phase) + (longint'(1) << CB);
      if (CB > 15) v = (v + (longint'(1) << (CB - 16))) >>> (CB - 15);
      else v = v <<< (15 - CB);
      if (v > 65536) v = 65536;
      if (v < 0) v = 0;
      return 17'(v);
   endfunction

   always @(posedge clock) begin
      logic [16:0] want;
      if (!reset) begin
         if (rsp_valid) begin
            if (wave_due.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %0d", $time, rsp_wave_value);
               mismatches++;
            end else begin
               want = wave_due.pop_front();
               words_checked++;
               if (rsp_wave_value !== want) begin
                  $display("%0t: wave_value expected %0d actual %0d", $time, want, rsp_wave_value);
                  mismatches++;
               end
            end
         end
      end
   end

   // hand one word to the block and wait until it is taken
   task automatic send_word(input logic [31:0] freq, input logic [47:0] tsec,
                            input longint typed, input bit may_idle);
      int gap;
      req_freq_hz <= freq;
      req_time_s  <= tsec;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      if (typed != NO_GLANCE)
         wave_due.push_back(17'(typed));
      else
         wave_due.push_back(doppler_wave(freq, tsec));
      words_sent++;
      if (may_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain(input int limit);
      int waited;
      waited = 0;
      while (wave_due.size() != 0 && waited < limit) begin
         @(posedge clock);
         waited++;
      end
   endtask

   initial begin
      logic [31:0] f;
      logic [47:0] t;
      int          mode;
      mismatches = 0;
      words_sent = 0;
      words_checked = 0;
      reset = 1'b1;
      start = 1'b0;
      req_freq_hz = '0;
      req_time_s = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_word(directed[i].freq, directed[i].tsec, directed[i].wave, 1'b1);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         mode = $urandom_range(0, 3);
         f = $urandom();
         t = {16'($urandom()), 32'($urandom())};
         if (mode == 1) f = f >> $urandom_range(0, 31);
         if (mode == 2) t = t >> $urandom_range(0, 47);
         if (mode == 3) begin
            f = f >> $urandom_range(8, 31);
            t = t >> $urandom_range(8, 47);
         end
         // hold off once so the pipeline empties completely
         if (n == RANDOM_WORDS / 2) begin
            start <= 1'b0;
            drain(10 * LATENCY);
         end
         send_word(f, t, NO_GLANCE, n < RANDOM_WORDS - 100);
      end
      start <= 1'b0;

      drain(10 * LATENCY);
      repeat (LATENCY + 10) @(posedge clock);
      if (wave_due.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, wave_due.size());
         mismatches++;
      end
      $display("covered %0d words (directed extremes, zero frequency, random wrap cases)",
               words_sent);
      $display("checked %0d results against the phase predictor", words_checked);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout waiting for the block");
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/dmws_pkg.sv
sv/dmws_cordic.sv
sv/doppler_modulated_wave_sample_unit.sv
tb/sv/tb_top.sv
